/* rtl/core/lspd_pkg.sv */
// Package for the laser scan point decimator: payload structs, constants,
// CORDIC arctangent table. Used by every module in rtl/core.
package lspd_pkg;

	typedef struct packed {
		logic [15:0] range_mm;
		logic [11:0] sample_index;
		logic        scan_start;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [11:0]        point_index;
	} out_item_t;

	// Work handed from front to back: range, reduced angle, flip, index, scan start.
	typedef struct packed {
		logic [15:0]        range_mm;
		logic signed [18:0] theta;
		logic               flip;
		logic [11:0]        sample_index;
		logic               scan_start;
	} job_t;

	localparam int ANGLE_MAX_Q16  = 103546;
	localparam int RANGE_LIMIT_MM = 20000;
	localparam int ROT45_Q16      = 51472;
	localparam int PI_Q16         = 205887;
	localparam int TWO_PI_Q16     = 411775;
	localparam int HALF_PI_Q16    = 102944;
	localparam int CORDIC_GAIN    = 39797;
	localparam int CORDIC_STEPS   = 16;

	localparam logic [2:0] REG_FIRST_INDEX = 3'd0;
	localparam logic [2:0] REG_ANGLE_START = 3'd1;
	localparam logic [2:0] REG_ANGLE_STEP  = 3'd2;
	localparam logic [2:0] REG_MIN_SPACING = 3'd3;
	localparam logic [2:0] REG_PROJ_XX     = 3'd4;
	localparam logic [2:0] REG_PROJ_XY     = 3'd5;
	localparam logic [2:0] REG_PROJ_YX     = 3'd6;
	localparam logic [2:0] REG_PROJ_YY     = 3'd7;

	function automatic logic [16:0] atan_q16(input logic [3:0] i);
		logic [16:0] r;
		begin
			case (i)
				4'd0: r = 17'd51472;
				4'd1: r = 17'd30386;
				4'd2: r = 17'd16055;
				4'd3: r = 17'd8150;
				4'd4: r = 17'd4091;
				4'd5: r = 17'd2047;
				4'd6: r = 17'd1024;
				4'd7: r = 17'd512;
				4'd8: r = 17'd256;
				4'd9: r = 17'd128;
				4'd10: r = 17'd64;
				4'd11: r = 17'd32;
				4'd12: r = 17'd16;
				4'd13: r = 17'd8;
				4'd14: r = 17'd4;
				default: r = 17'd2;
			endcase
			return r;
		end
	endfunction

endpackage

/* rtl/core/lspd_front.sv */
// Front end: window and range checks, angle computation and reduction.
// Depends on lspd_pkg. Two stages, one item at a time.
module lspd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lspd_pkg::in_item_t in_item,
	input  logic [11:0]        first_index,
	input  logic signed [19:0] scan_angle_start,
	input  logic [15:0]        angle_step,
	output logic               job_valid,
	input  logic               job_stall,
	output lspd_pkg::job_t     job
);
	logic               busy_q;
	lspd_pkg::in_item_t item_s1;
	logic signed [29:0] raw_s1;
	logic               pass_s1;
	logic               ph_q;
	logic signed [29:0] t0, t1, t2;
	logic signed [29:0] t_mod;
	logic               flip;
	logic signed [29:0] t_fin;
	logic               window_ok;

	assign in_stall = busy_q;

	// Reduce theta into [-pi, pi], then fold it into +-pi/2 with a flip: raw is bounded, so a few compares suffice.
	always_comb begin
		t0 = raw_s1 + 30'(lspd_pkg::ROT45_Q16);
		t1 = t0;
		if (t1 < 0) t1 = t1 + 30'(lspd_pkg::TWO_PI_Q16);
		if (t1 < 0) t1 = t1 + 30'(lspd_pkg::TWO_PI_Q16);
		if (t1 < 0) t1 = t1 + 30'(lspd_pkg::TWO_PI_Q16);
		t2 = t1;
		if (t2 > 30'(lspd_pkg::PI_Q16)) t2 = t2 - 30'(lspd_pkg::TWO_PI_Q16);
		t_mod = t2;
		flip  = 1'b0;
		t_fin = t_mod;
		if (t_mod > 30'(lspd_pkg::HALF_PI_Q16)) begin
			t_fin = t_mod - 30'(lspd_pkg::PI_Q16);
			flip  = 1'b1;
		end else if (t_mod < -30'(lspd_pkg::HALF_PI_Q16)) begin
			t_fin = t_mod + 30'(lspd_pkg::PI_Q16);
			flip  = 1'b1;
		end
	end

	assign window_ok = (raw_s1 <= 30'(lspd_pkg::ANGLE_MAX_Q16));

	// Stage 1: capture and multiply; stage 2: classify and offer the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ph_q      <= 1'b0;
			job_valid <= 1'b0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
			end
		end else if (!ph_q) begin
			ph_q <= 1'b1;
			if (pass_s1 && window_ok) job_valid <= 1'b1;
			else busy_q <= 1'b0;
		end else if (!job_stall) begin
			job_valid <= 1'b0;
			busy_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			item_s1 <= in_item;
			raw_s1  <= 30'(scan_angle_start) +
				$signed({1'b0, 29'(in_item.sample_index) * 29'(angle_step)});
			pass_s1 <= (in_item.sample_index >= first_index) &&
				(in_item.range_mm < 16'(lspd_pkg::RANGE_LIMIT_MM));
		end
		if (busy_q && !ph_q) begin
			job.range_mm     <= item_s1.range_mm;
			job.theta        <= 19'(t_fin);
			job.flip         <= flip;
			job.sample_index <= item_s1.sample_index;
			job.scan_start   <= item_s1.scan_start;
		end
	end

	// Scan start must clear last point even when the sample is dropped.
	// Forwarding a drop-only job from here is not needed: see the back end clr_last flag.
endmodule

/* rtl/core/lspd_queue.sv */
// Two-entry queue between front and back end. Depends on lspd_pkg.
module lspd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  lspd_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lspd_pkg::job_t rd_data
);
	lspd_pkg::job_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && rd_ready;

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

/* rtl/core/lspd_back.sv */
// Back end: CORDIC rotation, spacing test, projection and output register.
// Depends on lspd_pkg. One job at a time, sequenced by a small state machine.
module lspd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  lspd_pkg::job_t     job,
	input  logic               clr_last,
	output logic               idle,
	input  logic [31:0]        min_spacing_sq,
	input  logic signed [15:0] proj_xx,
	input  logic signed [15:0] proj_xy,
	input  logic signed [15:0] proj_yx,
	input  logic signed [15:0] proj_yy,
	output logic               out_valid,
	input  logic               out_stall,
	output lspd_pkg::out_item_t out_item
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_DIST = 3'd3;
	localparam logic [2:0] ST_PX   = 3'd4;
	localparam logic [2:0] ST_PY   = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]         st_q;
	logic [3:0]         it_q;
	logic signed [33:0] x_q, y_q;
	logic signed [19:0] t_q;
	logic               flip_q;
	logic [11:0]        idx_q;
	logic signed [15:0] px_q, py_q, lx_q, ly_q;
	logic               have_q;
	logic signed [31:0] dxx, dyy;
	logic signed [15:0] ox_q;
	logic signed [33:0] xs, ys, xn, yn, xf, yf;
	logic signed [17:0] xr, yr;
	logic signed [16:0] dx, dy;
	logic signed [31:0] m0, m1;
	logic signed [33:0] acc;
	logic signed [19:0] pr;
	logic signed [15:0] psat;
	logic [32:0]        sep_sq;
	logic signed [15:0] c0, c1;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) return 16'sh7fff;
		if (v < -20'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	assign idle      = (st_q == ST_IDLE);
	assign job_ready = (st_q == ST_IDLE) && !clr_last;

	// One CORDIC micro-rotation per cycle, plus rounding, spacing distance and projection math.
	always_comb begin
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		if (!t_q[19]) begin
			xn = x_q - ys;
			yn = y_q + xs;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
		end
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xr = 18'((xf + 34'sd32768) >>> 16);
		yr = 18'((yf + 34'sd32768) >>> 16);
		dx = 17'(px_q) - 17'(lx_q);
		dy = 17'(py_q) - 17'(ly_q);
		dxx = dx * dx;
		dyy = dy * dy;
		sep_sq = 33'($unsigned(dxx)) + 33'($unsigned(dyy));
		c0 = (st_q == ST_PX) ? proj_xx : proj_yx;
		c1 = (st_q == ST_PX) ? proj_xy : proj_yy;
		m0 = c0 * px_q;
		m1 = c1 * py_q;
		acc = 34'(m0) + 34'(m1) + 34'sd8192;
		pr = 20'(acc >>> 14);
		if ((acc >>> 14) > 34'sd32767) psat = 16'sh7fff;
		else if ((acc >>> 14) < -34'sd32768) psat = 16'sh8000;
		else psat = pr[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			it_q      <= 4'd0;
			have_q    <= 1'b0;
			lx_q      <= 16'sd0;
			ly_q      <= 16'sd0;
			out_valid <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (clr_last) have_q <= 1'b0;
					else if (job_valid) begin
						if (job.scan_start) have_q <= 1'b0;
						it_q <= 4'd0;
						st_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					it_q <= it_q + 4'd1;
					if (it_q == 4'(lspd_pkg::CORDIC_STEPS - 1)) st_q <= ST_RND;
				end
				ST_RND: st_q <= ST_DIST;
				ST_DIST: begin
					if (have_q && sep_sq <= {1'b0, min_spacing_sq}) st_q <= ST_IDLE;
					else begin
						lx_q   <= px_q;
						ly_q   <= py_q;
						have_q <= 1'b1;
						st_q   <= ST_PX;
					end
				end
				ST_PX: st_q <= ST_PY;
				ST_PY: begin
					out_valid <= 1'b1;
					st_q      <= ST_OUT;
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					st_q      <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q    <= $signed({2'b0,
					32'(job.range_mm) * 32'(lspd_pkg::CORDIC_GAIN)});
				y_q    <= 34'sd0;
				t_q    <= 20'(job.theta);
				flip_q <= job.flip;
				idx_q  <= job.sample_index;
			end
			ST_ROT: begin
				x_q <= xn;
				y_q <= yn;
				t_q <= t_q[19] ? t_q + 20'(lspd_pkg::atan_q16(it_q))
					: t_q - 20'(lspd_pkg::atan_q16(it_q));
			end
			ST_RND: begin
				px_q <= sat16(20'(xr));
				py_q <= sat16(20'(yr));
			end
			ST_DIST: ;
			ST_PX: ox_q <= psat;
			ST_PY: begin
				out_item.point_x     <= ox_q;
				out_item.point_y     <= psat;
				out_item.point_index <= idx_q;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/core/laser_scan_point_decimator.sv */
// Laser scan point decimator top level.
// Input channel in_valid/in_stall carries one range sample (in_item).
// Output channel out_valid/out_stall carries one kept point (out_item).
// Config: cfg_we writes cfg_data into register cfg_index; the user must write only while idle.
// Front end takes one item at a time: it checks index window and range,
// forms the angle and folds it into +-pi/2, then queues a job.
// Back end runs a 16-step CORDIC, one step per cycle, then a spacing test
// and two projection multiplies; it takes a new job only when idle, and a
// sample that fails the spacing test skips the projections.
// A transaction with scan start is held off until the front end, queue
// and back end are empty, then clears the last kept point.
// Reset clears the queue, the last point and the registers to identity
// projection. A stalled receiver holds the output register and backs up
// the two-entry queue, then the front end.
module laser_scan_point_decimator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lspd_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lspd_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	logic [11:0]        first_index_q;
	logic signed [19:0] angle_start_q;
	logic [15:0]        angle_step_q;
	logic [31:0]        spacing_q;
	logic signed [15:0] pxx_q, pxy_q, pyx_q, pyy_q;
	logic               fj_valid, fj_stall, qv, qr;
	lspd_pkg::job_t     fj, qj;
	logic               front_stall, clr_last, back_idle, scan_hold;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_index_q <= 12'd0;
			angle_start_q <= 20'sd0;
			angle_step_q  <= 16'd0;
			spacing_q     <= 32'd0;
			pxx_q         <= 16'sd16384;
			pxy_q         <= 16'sd0;
			pyx_q         <= 16'sd0;
			pyy_q         <= 16'sd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lspd_pkg::REG_FIRST_INDEX: first_index_q <= cfg_data[11:0];
				lspd_pkg::REG_ANGLE_START: angle_start_q <= cfg_data[19:0];
				lspd_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_data[15:0];
				lspd_pkg::REG_MIN_SPACING: spacing_q     <= cfg_data;
				lspd_pkg::REG_PROJ_XX:     pxx_q         <= cfg_data[15:0];
				lspd_pkg::REG_PROJ_XY:     pxy_q         <= cfg_data[15:0];
				lspd_pkg::REG_PROJ_YX:     pyx_q         <= cfg_data[15:0];
				lspd_pkg::REG_PROJ_YY:     pyy_q         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A scan start on an item the front end drops still clears the last
	// point; hold input until every older job is finished so ordering is kept.
	assign scan_hold = in_item.scan_start && (qv || fj_valid || !back_idle);
	assign in_stall  = front_stall || scan_hold;
	assign clr_last  = in_valid && !in_stall && in_item.scan_start;

	lspd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid && !scan_hold),
		.in_stall(front_stall), .in_item(in_item),
		.first_index(first_index_q), .scan_angle_start(angle_start_q),
		.angle_step(angle_step_q),
		.job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
	);

	lspd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj)
	);

	lspd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(qv), .job_ready(qr), .job(qj), .clr_last(clr_last),
		.idle(back_idle),
		.min_spacing_sq(spacing_q),
		.proj_xx(pxx_q), .proj_xy(pxy_q), .proj_yx(pyx_q), .proj_yy(pyy_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule

/* test/lspd_checker.sv */
// Checker for the laser scan point decimator: watches config writes and both
// channels, predicts kept points and compares them. Depends on lspd_pkg.
`timescale 1ns / 1ps
module lspd_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  lspd_pkg::in_item_t   in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  lspd_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   mismatches,
	output int                   points_waiting
);
	localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	// Shadow copy of the block's registers and spacing state
	logic [11:0]         first_idx;
	logic signed [19:0]  angle_start;
	logic [15:0]         angle_step;
	logic [31:0]         spacing_sq;
	logic signed [15:0]  proj [4];
	longint              prev_x, prev_y;
	bit                  have_prev;
	lspd_pkg::out_item_t expected_points[$];

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Work out the kept point, if any, for one sample transaction
	function automatic void predict_point(lspd_pkg::in_item_t it);
		longint raw, t, x, y, nx, dx, dy;
		longint unsigned sep_sq;
		bit flip;
		lspd_pkg::out_item_t p;
		flip = 0;
		if (it.scan_start) have_prev = 0;
		if (it.sample_index < first_idx) return;
		raw = longint'(angle_start) + longint'(it.sample_index) * longint'(angle_step);
		if (raw > lspd_pkg::ANGLE_MAX_Q16) return;
		if (it.range_mm >= lspd_pkg::RANGE_LIMIT_MM) return;
		// Fold angle into +-pi/2
		t = (raw + lspd_pkg::ROT45_Q16) % lspd_pkg::TWO_PI_Q16;
		if (t < 0) t += lspd_pkg::TWO_PI_Q16;
		if (t > lspd_pkg::PI_Q16) t -= lspd_pkg::TWO_PI_Q16;
		if (t > lspd_pkg::HALF_PI_Q16) begin
			t -= lspd_pkg::PI_Q16;
			flip = 1;
		end else if (t < -lspd_pkg::HALF_PI_Q16) begin
			t += lspd_pkg::PI_Q16;
			flip = 1;
		end
		x = longint'(it.range_mm) * lspd_pkg::CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (t >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				t -= ARCTAN_Q16[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				t += ARCTAN_Q16[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		x = clamp16((x + 32768) >>> 16);
		y = clamp16((y + 32768) >>> 16);
		// Drop points too close to the last kept one
		if (have_prev) begin
			dx = x - prev_x;
			dy = y - prev_y;
			sep_sq = longint'(dx * dx) + longint'(dy * dy);
			if (sep_sq <= spacing_sq) return;
		end
		prev_x = x;
		prev_y = y;
		have_prev = 1;
		p.point_x = 16'(clamp16((longint'(proj[0]) * x + longint'(proj[1]) * y + 8192) >>> 14));
		p.point_y = 16'(clamp16((longint'(proj[2]) * x + longint'(proj[3]) * y + 8192) >>> 14));
		p.point_index = it.sample_index;
		expected_points = {expected_points, p};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_idx = '0;
			angle_start = '0;
			angle_step = '0;
			spacing_sq = '0;
			proj[0] = 16384;
			proj[1] = 0;
			proj[2] = 0;
			proj[3] = 16384;
			prev_x = 0;
			prev_y = 0;
			have_prev = 0;
			expected_points.delete();
			mismatches = 0;
			points_waiting = 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					lspd_pkg::REG_FIRST_INDEX: first_idx = cfg_data[11:0];
					lspd_pkg::REG_ANGLE_START: angle_start = cfg_data[19:0];
					lspd_pkg::REG_ANGLE_STEP:  angle_step = cfg_data[15:0];
					lspd_pkg::REG_MIN_SPACING: spacing_sq = cfg_data;
					lspd_pkg::REG_PROJ_XX:     proj[0] = cfg_data[15:0];
					lspd_pkg::REG_PROJ_XY:     proj[1] = cfg_data[15:0];
					lspd_pkg::REG_PROJ_YX:     proj[2] = cfg_data[15:0];
					lspd_pkg::REG_PROJ_YY:     proj[3] = cfg_data[15:0];
					default: ;
				endcase
			end
			// Compare each output transaction with the oldest expected point
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected point x=%0d y=%0d idx=%0d", $realtime,
							out_item.point_x, out_item.point_y, out_item.point_index);
				end else begin
					lspd_pkg::out_item_t e;
					e = expected_points.pop_front();
					if (e !== out_item) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: point mismatch exp x=%0d y=%0d idx=%0d",
								" got x=%0d y=%0d idx=%0d"},
								$realtime, e.point_x, e.point_y, e.point_index,
								out_item.point_x, out_item.point_y, out_item.point_index);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_point(in_item);
			points_waiting = expected_points.size();
		end
	end
endmodule

/* test/tb_top.sv */
// Testbench top for the laser scan point decimator: clock, reset, config
// phases and sample stimulus; checking lives in lspd_checker. Needs lspd_pkg.
`timescale 1ns / 1ps
module tb_top;
	logic                clk, arst_n;
	logic                in_valid, in_stall, out_valid, out_stall;
	lspd_pkg::in_item_t  in_item;
	lspd_pkg::out_item_t out_item;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;
	int                  mismatches, points_waiting;
	int                  samples_sent, points_seen, idle_cycles;
	bit                  quiet, hold_req;
	int                  win_lo, win_hi;

	laser_scan_point_decimator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lspd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .points_waiting(points_waiting)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stall bursts, one long hold-off on request, none at the end
	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_stall <= 0;
				@(posedge clk);
			end else if (hold_req) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else begin
				out_stall <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// Count cycles with no transaction on either channel and no config write, and count points seen
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 4000) begin
			$display("Watchdog expired with %0d points outstanding", points_waiting);
			$display("== FAIL ==");
			$finish;
		end
		if (out_valid && !out_stall) points_seen <= points_seen + 1;
	end

	// Present one register write; the caller drops cfg_we after the last one
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Wait for outstanding points, then for any dropped sample still in flight
	task automatic drain();
		while (points_waiting != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Load all registers and work out which indexes fall inside the window
	task automatic configure(int first, int start, int step, logic [31:0] spacing,
			int xx, int xy, int yx, int yy);
		longint hi;
		write_reg(lspd_pkg::REG_FIRST_INDEX, 32'(first));
		write_reg(lspd_pkg::REG_ANGLE_START, 32'(start));
		write_reg(lspd_pkg::REG_ANGLE_STEP, 32'(step));
		write_reg(lspd_pkg::REG_MIN_SPACING, spacing);
		write_reg(lspd_pkg::REG_PROJ_XX, 32'(xx));
		write_reg(lspd_pkg::REG_PROJ_XY, 32'(xy));
		write_reg(lspd_pkg::REG_PROJ_YX, 32'(yx));
		write_reg(lspd_pkg::REG_PROJ_YY, 32'(yy));
		cfg_we <= 0;
		if (step == 0) hi = (start <= lspd_pkg::ANGLE_MAX_Q16) ? 4095 : -1;
		else if (start > lspd_pkg::ANGLE_MAX_Q16) hi = -1;
		else hi = (longint'(lspd_pkg::ANGLE_MAX_Q16) - start) / step;
		win_lo = first;
		win_hi = (hi > 4095) ? 4095 : int'(hi);
	endtask

	task automatic send_sample(int rng, int idx, bit first_of_scan);
		lspd_pkg::in_item_t it;
		it.range_mm = 16'(rng);
		it.sample_index = 12'(idx);
		it.scan_start = first_of_scan;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	// Mostly in-window scans with valid ranges, with noise mixed in
	task automatic random_samples(int n);
		int idx, rng;
		idx = win_lo;
		for (int k = 0; k < n; k++) begin
			if (win_lo > win_hi || $urandom_range(0, 6) == 0) begin
				send_sample($urandom_range(0, 65535), $urandom_range(0, 4095),
					$urandom_range(0, 9) == 0);
			end else begin
				rng = ($urandom_range(0, 9) == 0) ? $urandom_range(19990, 20010)
					: $urandom_range(0, 19999);
				idx = ($urandom_range(0, 15) == 0 || idx > win_hi) ? win_lo
					: idx + $urandom_range(0, 3);
				if (idx > win_hi) idx = win_hi;
				send_sample(rng, idx, idx == win_lo);
			end
		end
		in_valid <= 0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_index = lspd_pkg::REG_FIRST_INDEX;
		cfg_data = '0;
		samples_sent = 0;
		points_seen = 0;
		idle_cycles = 0;
		quiet = 0;
		hold_req = 0;
		win_lo = 0;
		win_hi = 4095;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset registers, every sample at angle zero plus 45 degrees
		send_sample(0, 0, 1);
		send_sample(19999, 4095, 0);
		send_sample(19999, 4095, 0);
		send_sample(20000, 5, 0);
		send_sample(65535, 6, 1);
		send_sample(1000, 7, 1);
		in_valid <= 0;
		drain();

		// Directed: window from -pi/2, edge samples, spacing and scan start
		configure(10, -102944, 400, 32'd10000, 16384, 0, 0, 16384);
		send_sample(500, 9, 1);
		send_sample(500, 10, 1);
		send_sample(500, 10, 0);
		send_sample(560, 10, 0);
		send_sample(500, 10, 1);
		send_sample(1234, win_hi, 0);
		send_sample(1234, win_hi + 1, 0);
		send_sample(20000, 200, 0);
		send_sample(19999, 257, 0);
		send_sample(0, 300, 1);
		in_valid <= 0;
		drain();

		// Saturating projection with a long receiver hold-off
		configure(0, -150000, 700, 32'd250000, 32767, -32768, -32768, 32767);
		hold_req = 1;
		random_samples(120);
		drain();

		// Extremes: widest window index, wrapped angles, maximal spacing
		configure(4095, -524288, 0, 32'hFFFFFFFF, -32768, 32767, 32767, -32768);
		send_sample(19999, 4095, 1);
		send_sample(100, 4095, 0);
		send_sample(100, 4094, 1);
		in_valid <= 0;
		drain();
		configure(0, 524287, 65535, 32'd0, 16384, 0, 0, 16384);
		random_samples(30);
		drain();
		configure(0, -524288, 65535, 32'd0, 0, 16384, 16384, 0);
		random_samples(40);
		drain();

		// Random register settings
		for (int ph = 0; ph < 3; ph++) begin
			configure($urandom_range(0, 200), int'($urandom_range(0, 250000)) - 200000,
				$urandom_range(0, 2000), $urandom_range(0, 1 << 20),
				int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
				int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
			random_samples(100);
			drain();
		end

		// Final stretch at full rate
		configure(0, -102944, 300, 32'd400, 16384, 0, 0, 16384);
		quiet = 1;
		random_samples(120);
		drain();

		$display("Sent %0d samples across ten register settings; %0d points came out.",
			samples_sent, points_seen);
		if (mismatches == 0 && points_waiting == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d points never came", mismatches, points_waiting);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
